[src/ofm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_pkg
// Shared types and constants of the overlap-add frame merge unit.
// ----------------------------------------------------------------------------
package ofm_pkg;

	localparam int MAX_FRAME_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int TADDR_W   = CFG_W - 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HOP          = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(1024);
	localparam logic [CFG_W-1:0] HOP_RESET = CFG_W'(512);

	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 2;

	typedef struct packed {
		logic               rd;
		logic               wr;
		logic [TADDR_W-1:0] addr;
	} tail_ctrl_t;

endpackage

[src/ofm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_if
// Valid/ready channels of the overlap-add frame merge unit.
// ----------------------------------------------------------------------------
interface ofm_in_if import ofm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_left;
	logic signed [SAMPLE_BITS-1:0] sample_right;

	modport source (output valid, output sample_left, output sample_right, input ready);
	modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

interface ofm_out_if import ofm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [SAMPLE_BITS:0] out_left;
	logic signed [SAMPLE_BITS:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface

interface ofm_cfg_if import ofm_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/ofm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_seq
// Configuration registers, frame position counter and tail access control.
// ----------------------------------------------------------------------------
module ofm_seq import ofm_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ofm_cfg_if.sink    cfg,
	input  logic       fire,
	output tail_ctrl_t ctrl,
	output logic       emit_s1,
	output logic       busy
);

	logic [CFG_W-1:0] len_q, hop_q;
	logic [CFG_W-1:0] n_q, h_q, nmh_q;
	logic [CFG_W-1:0] pos_q;
	logic             first_q;
	logic             busy_q;

	logic [CFG_W-1:0] n_c, lo_c, h_c;
	logic [CFG_W-1:0] j, j_inc, k;
	logic             overlap, emit_only, wrap, cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && (cfg.index == REG_FRAME_LENGTH || cfg.index == REG_HOP);
	assign busy      = busy_q;

	// effective length and hop
	always_comb begin
		if (len_q < CFG_W'(2)) begin
			n_c = CFG_W'(2);
		end else if (32'(len_q) > MAX_FRAME) begin
			n_c = CFG_W'(MAX_FRAME);
		end else begin
			n_c = len_q;
		end
		lo_c = CFG_W'(({1'b0, n_c} + (CFG_W + 1)'(1)) >> 1);
		h_c  = (hop_q < lo_c) ? lo_c : hop_q;
		if (h_c > n_c) begin
			h_c = n_c;
		end
	end

	always_ff @(posedge clk) begin
		n_q   <= n_c;
		h_q   <= h_c;
		nmh_q <= n_c - h_c;
	end

	always_comb begin
		j         = (pos_q >= n_q) ? '0 : pos_q;
		overlap   = (j < nmh_q) && !first_q;
		emit_only = j < h_q;
		k         = j - h_q;
		j_inc     = j + CFG_W'(1);
		wrap      = j_inc >= n_q;
		ctrl.rd   = fire && overlap;
		ctrl.wr   = fire && !overlap && !emit_only;
		ctrl.addr = overlap ? j[TADDR_W-1:0] : k[TADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_RESET;
			hop_q   <= HOP_RESET;
			pos_q   <= '0;
			first_q <= 1'b1;
			busy_q  <= 1'b1;
			emit_s1 <= 1'b0;
		end else begin
			emit_s1 <= fire && (overlap || emit_only);
			if (cfg_wr) begin
				if (cfg.index == REG_FRAME_LENGTH) begin
					len_q <= cfg.data;
				end else begin
					hop_q <= cfg.data;
				end
				pos_q   <= '0;
				first_q <= 1'b1;
				busy_q  <= 1'b1;
			end else begin
				busy_q <= 1'b0;
				if (fire) begin
					pos_q <= wrap ? '0 : j_inc;
					if (wrap) begin
						first_q <= 1'b0;
					end
				end
			end
		end
	end

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (pos_q == '0 && first_q && busy_q))
		else $error("framing not restarted after register write");

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.rd && ctrl.wr))
		else $error("tail read and write in one transaction");

	a_wrap_clears_first: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && wrap && !cfg_wr) |=> (!first_q && pos_q == '0))
		else $error("frame end not handled");

endmodule

[src/ofm_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_lane
// One channel: tail memory and overlap adder.
// ----------------------------------------------------------------------------
module ofm_lane import ofm_pkg::*; #(
	parameter int MAX_FRAME   = MAX_FRAME_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          fire,
	input  tail_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS:0]   sum
);

	localparam int HALF       = MAX_FRAME / 2;
	localparam int TAIL_LIMIT = 1 << TADDR_W;
	localparam int TAIL_DEPTH = (HALF < TAIL_LIMIT) ? HALF : TAIL_LIMIT;
	localparam int AW         = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;

	logic signed [SAMPLE_BITS-1:0] tail_mem [TAIL_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          add_s1;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			tail_mem[ctrl.addr[AW-1:0]] <= sample;
		end
		if (ctrl.rd) begin
			rd_s1 <= tail_mem[ctrl.addr[AW-1:0]];
		end
		if (fire) begin
			sample_s1 <= sample;
			add_s1    <= ctrl.rd;
		end
	end

	assign sum = {sample_s1[SAMPLE_BITS-1], sample_s1}
		+ (add_s1 ? {rd_s1[SAMPLE_BITS-1], rd_s1} : (SAMPLE_BITS + 1)'(0));

endmodule

[src/ofm_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofm_merge
// Joins the lane sums into one result and queues it for the output channel.
// ----------------------------------------------------------------------------
module ofm_merge import ofm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic signed [SAMPLE_BITS:0] left,
	input  logic signed [SAMPLE_BITS:0] right,
	output logic                        can_accept,
	ofm_out_if.source                   merged
);

	logic signed [SAMPLE_BITS:0] left_q  [FIFO_DEPTH];
	logic signed [SAMPLE_BITS:0] right_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0]       cnt_q;
	logic                        pop;

	assign pop              = merged.valid && merged.ready;
	assign merged.valid     = cnt_q != '0;
	assign merged.out_left  = left_q[rd_ptr_q];
	assign merged.out_right = right_q[rd_ptr_q];
	assign can_accept       = ({1'b0, cnt_q} + (FIFO_CNT_W + 1)'(push))
		< (FIFO_CNT_W + 1)'(FIFO_DEPTH);

	function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
		ptr_next = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			left_q[wr_ptr_q]  <= left;
			right_q[wr_ptr_q] <= right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < FIFO_CNT_W'(FIFO_DEPTH) || pop))
		else $error("result queue overflow");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= FIFO_DEPTH)
		else $error("result queue count out of range");

endmodule

[src/overlap_add_frame_merge_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_add_frame_merge_unit
// Overlap-add merge of successive stereo frames with a per-channel tail store.
// ----------------------------------------------------------------------------
// samples: one stereo sample of the current frame per transaction.
// merged: one merged stereo sample per transaction; samples stored as the new
//   tail produce no transaction, so the output count per frame equals the effective hop.
// cfg: register 0 is frame_length, register 1 is hop; any write to either
//   restarts framing, and the following frame has no tail to add.
// Path: a sample and its tail memory read are registered in each lane, then
//   their sum is written into the result queue that drives merged.
// Throughput: one sample per cycle while samples.ready is high, set by the at
//   most one tail memory access each sample makes in each channel lane.
// Reset: registers return to 1024 and 512, position to zero, queue empties;
//   samples.ready is held low by the busy flag after reset and after each register
//   write while the effective length and hop are recomputed.
// Stall: a three-entry result queue sits behind the adder stage; when the
//   queue and the adder stage together hold three results, samples.ready
//   drops until merged takes a result.
// ----------------------------------------------------------------------------
module overlap_add_frame_merge_unit import ofm_pkg::*; #(
	parameter int MAX_FRAME   = MAX_FRAME_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ofm_in_if.sink    samples,
	ofm_out_if.source merged,
	ofm_cfg_if.sink   cfg
);

	tail_ctrl_t                  ctrl;
	logic                        fire;
	logic                        emit_s1;
	logic                        busy;
	logic                        can_accept;
	logic signed [SAMPLE_BITS:0] sum_left, sum_right;

	assign samples.ready = can_accept && !busy;
	assign fire          = samples.valid && samples.ready;

	ofm_seq #(
		.MAX_FRAME (MAX_FRAME)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.ctrl    (ctrl),
		.emit_s1 (emit_s1),
		.busy    (busy)
	);

	ofm_lane #(
		.MAX_FRAME   (MAX_FRAME),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_left (
		.clk    (clk),
		.fire   (fire),
		.ctrl   (ctrl),
		.sample (samples.sample_left),
		.sum    (sum_left)
	);

	ofm_lane #(
		.MAX_FRAME   (MAX_FRAME),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_right (
		.clk    (clk),
		.fire   (fire),
		.ctrl   (ctrl),
		.sample (samples.sample_right),
		.sum    (sum_right)
	);

	ofm_merge #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (emit_s1),
		.left       (sum_left),
		.right      (sum_right),
		.can_accept (can_accept),
		.merged     (merged)
	);

endmodule
